FILE: rtl/core/neighbor_fault_detector_assert.svh
// Assertion macros for the neighbour fault detector
`ifndef NEIGHBOR_FAULT_DETECTOR_ASSERT_SVH
`define NEIGHBOR_FAULT_DETECTOR_ASSERT_SVH

// same-cycle implication
`define NFD_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define NFD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/nfd_pkg.sv
package nfd_pkg;

    localparam int TBL_N  = 16;
    localparam int IDX_W  = $clog2(TBL_N);
    localparam int KEY_W  = 64;
    localparam int ADDR_W = 48;
    localparam int TIME_W = 32;
    localparam int FLT_W  = 16;

    localparam logic [TIME_W-1:0] DEFAULT_RETRY = TIME_W'(30 * 60);

    localparam logic [1:0] CMD_HEARD = 2'd0;
    localparam logic [1:0] CMD_TICK  = 2'd1;
    localparam logic [1:0] CMD_QSWP  = 2'd2;
    localparam logic [1:0] CMD_BSWP  = 2'd3;

    localparam logic [1:0] CFG_TIMEOUT = 2'd0;
    localparam logic [1:0] CFG_THRESH  = 2'd1;
    localparam logic [1:0] CFG_RETRY   = 2'd2;

    localparam logic [2:0] EV_BCAST   = 3'd0;
    localparam logic [2:0] EV_UP      = 3'd1;
    localparam logic [2:0] EV_DOWN    = 3'd2;
    localparam logic [2:0] EV_BLOCK   = 3'd3;
    localparam logic [2:0] EV_UNBLOCK = 3'd4;
    localparam logic [2:0] EV_FULL    = 3'd5;

    typedef struct packed {
        logic [KEY_W-1:0]  key;
        logic [ADDR_W-1:0] addr;
        logic [TIME_W-1:0] tm;
        logic [FLT_W-1:0]  faults;
    } t_entry;

    typedef struct packed {
        logic wr_all;
        logic wr_time;
        logic wr_faults;
        logic clr;
    } t_cell_cmd;

    typedef struct packed {
        logic             hit;
        logic [IDX_W-1:0] hit_idx;
        t_entry           hit_entry;
        logic             free;
        logic [IDX_W-1:0] free_idx;
        logic             rd_valid;
        t_entry           rd_entry;
    } t_row_stat;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_HEARD,
        ST_BCAST,
        ST_LWALK,
        ST_QUAR,
        ST_BLK,
        ST_QWALK,
        ST_BWALK,
        ST_FIN
    } t_state;

endpackage

FILE: rtl/core/nfd_cell.sv
module nfd_cell (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  nfd_pkg::t_cell_cmd       i_cmd,
    input  nfd_pkg::t_entry          i_data,
    input  logic [nfd_pkg::KEY_W-1:0] i_key,
    input  logic                     i_free_in,
    input  logic                     i_hit_in,
    input  nfd_pkg::t_entry          i_sel_in,
    output logic                     o_free_out,
    output logic                     o_take,
    output logic                     o_hit_out,
    output nfd_pkg::t_entry          o_sel_out,
    output logic                     o_valid,
    output nfd_pkg::t_entry          o_entry
);

    logic            r_valid;
    nfd_pkg::t_entry r_entry;
    logic            hit_here;

    assign hit_here   = r_valid && (r_entry.key == i_key);
    assign o_hit_out  = i_hit_in | hit_here;
    assign o_sel_out  = hit_here ? r_entry : i_sel_in;
    assign o_take     = !r_valid && !i_free_in;
    assign o_free_out = i_free_in | !r_valid;
    assign o_valid    = r_valid;
    assign o_entry    = r_entry;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_cmd.wr_all) begin
            r_valid <= 1'b1;
        end else if (i_cmd.clr) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_all) begin
            r_entry <= i_data;
        end else begin
            if (i_cmd.wr_time) begin
                r_entry.tm <= i_data.tm;
            end
            if (i_cmd.wr_faults) begin
                r_entry.faults <= i_data.faults;
            end
        end
    end

endmodule

FILE: rtl/core/nfd_row.sv
module nfd_row (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic [nfd_pkg::IDX_W-1:0] i_wr_idx,
    input  nfd_pkg::t_cell_cmd        i_cmd,
    input  nfd_pkg::t_entry           i_data,
    input  logic [nfd_pkg::KEY_W-1:0] i_key,
    input  logic [nfd_pkg::IDX_W-1:0] i_rd_idx,
    output nfd_pkg::t_row_stat        o_stat
);

    localparam int N = nfd_pkg::TBL_N;

    logic               free_c [0:N];
    logic               hit_c  [0:N];
    nfd_pkg::t_entry    sel_c  [0:N];
    logic               take   [0:N-1];
    logic               vld    [0:N-1];
    nfd_pkg::t_entry    ent    [0:N-1];
    nfd_pkg::t_cell_cmd cmd    [0:N-1];

    assign free_c[0] = 1'b0;
    assign hit_c[0]  = 1'b0;
    assign sel_c[0]  = '0;

    for (genvar g = 0; g < N; g++) begin : g_cell
        assign cmd[g] = (i_wr_idx == nfd_pkg::IDX_W'(g)) ? i_cmd : '0;
        nfd_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_cmd      (cmd[g]),
            .i_data     (i_data),
            .i_key      (i_key),
            .i_free_in  (free_c[g]),
            .i_hit_in   (hit_c[g]),
            .i_sel_in   (sel_c[g]),
            .o_free_out (free_c[g+1]),
            .o_take     (take[g]),
            .o_hit_out  (hit_c[g+1]),
            .o_sel_out  (sel_c[g+1]),
            .o_valid    (vld[g]),
            .o_entry    (ent[g])
        );
    end

    always_comb begin
        logic [nfd_pkg::IDX_W-1:0] hidx;
        logic [nfd_pkg::IDX_W-1:0] fidx;
        hidx = '0;
        fidx = '0;
        for (int i = 0; i < N; i++) begin
            if (hit_c[i+1] && !hit_c[i]) begin
                hidx = hidx | nfd_pkg::IDX_W'(i);
            end
            if (take[i]) begin
                fidx = fidx | nfd_pkg::IDX_W'(i);
            end
        end
        o_stat.hit       = hit_c[N];
        o_stat.hit_idx   = hidx;
        o_stat.hit_entry = sel_c[N];
        o_stat.free      = free_c[N];
        o_stat.free_idx  = fidx;
        o_stat.rd_valid  = vld[i_rd_idx];
        o_stat.rd_entry  = ent[i_rd_idx];
    end

endmodule

FILE: rtl/core/neighbor_fault_detector.sv
// Neighbour fault detector: keeps live, quarantine and block tables of sixteen slots,
// each a row of cells that search by key combinationally and pass the first free
// slot along the row. A tick or a quarantine or unblock sweep walks one slot per
// cycle unless a result held at the output stalls it, with a quarantine step after
// a live slot times out and a block step when faults pass the threshold. Commands
// travel in s_axis_tuser; the last result of each request carries m_axis_tlast.
// Registers are written through i_cfg_we/i_cfg_idx/i_cfg_data; the user must write
// them only while no request is in progress, as the block does not enforce this.
module neighbor_fault_detector (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    input  logic [151:0]  s_axis_tdata,   // now_seconds, node_key, node_addr, id_complete
    input  logic [1:0]    s_axis_tuser,   // command
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    output logic [111:0]  m_axis_tdata,   // event_key, event_addr
    output logic [2:0]    m_axis_tuser,   // event_kind
    output logic          m_axis_tlast,
    input  logic          i_cfg_we,
    input  logic [1:0]    i_cfg_idx,
    input  logic [31:0]   i_cfg_data
);

    `include "neighbor_fault_detector_assert.svh"

    localparam int TW = nfd_pkg::TIME_W;
    localparam int IW = nfd_pkg::IDX_W;

    logic [TW-1:0]             r_timeout;
    logic [nfd_pkg::FLT_W-1:0] r_thr;
    logic [TW-1:0]             r_retry;
    logic [TW-1:0]             r_hold;
    logic [48:0]               prod;

    nfd_pkg::t_state           r_state, n_state;
    logic [IW-1:0]             r_idx, n_idx;
    logic [1:0]                r_cmd;
    logic [TW-1:0]             r_now;
    logic [nfd_pkg::KEY_W-1:0] r_key;
    logic [nfd_pkg::ADDR_W-1:0] r_addr;
    logic                      r_cmpl;
    logic [nfd_pkg::KEY_W-1:0] r_k, n_k;
    logic [nfd_pkg::ADDR_W-1:0] r_a, n_a;
    logic [TW-1:0]             r_h, n_h;

    logic                      r_out_v;
    logic [2:0]                r_out_kind;
    logic [nfd_pkg::KEY_W-1:0] r_out_key;
    logic [nfd_pkg::ADDR_W-1:0] r_out_addr;
    logic                      r_out_last;
    logic                      r_pend_v;
    logic [2:0]                r_pend_kind;
    logic [nfd_pkg::KEY_W-1:0] r_pend_key;
    logic [nfd_pkg::ADDR_W-1:0] r_pend_addr;

    logic                      accept, can_emit, emit, push_last;
    logic [2:0]                em_kind;
    logic [nfd_pkg::KEY_W-1:0] em_key;
    logic [nfd_pkg::ADDR_W-1:0] em_addr;

    logic [IW-1:0]             l_wi, q_wi, b_wi;
    nfd_pkg::t_cell_cmd        l_cmd, q_cmd, b_cmd;
    nfd_pkg::t_entry           l_dat, q_dat, b_dat;
    nfd_pkg::t_row_stat        l_st, q_st, b_st;

    nfd_pkg::t_state           ret_state;
    logic                      last_slot;
    logic [nfd_pkg::FLT_W-1:0] newf;

    assign s_axis_tready = (r_state == nfd_pkg::ST_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign can_emit      = !r_out_v || m_axis_tready;

    assign m_axis_tvalid = r_out_v;
    assign m_axis_tuser  = r_out_kind;
    assign m_axis_tdata  = {r_out_addr, r_out_key};
    assign m_axis_tlast  = r_out_last;

    // configuration
    assign prod = {{17{1'b0}}, r_timeout} * {{33{1'b0}}, r_thr} * 49'd2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout <= '0;
            r_thr     <= '0;
            r_retry   <= nfd_pkg::DEFAULT_RETRY;
            r_hold    <= '0;
        end else begin
            r_hold <= (|prod[48:32]) ? {TW{1'b1}} : prod[31:0];
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    nfd_pkg::CFG_TIMEOUT: r_timeout <= i_cfg_data;
                    nfd_pkg::CFG_THRESH:  r_thr     <= i_cfg_data[nfd_pkg::FLT_W-1:0];
                    nfd_pkg::CFG_RETRY:   r_retry   <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    nfd_row u_live (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_wr_idx (l_wi), .i_cmd (l_cmd),
        .i_data (l_dat), .i_key (r_key), .i_rd_idx (r_idx), .o_stat (l_st)
    );
    nfd_row u_quar (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_wr_idx (q_wi), .i_cmd (q_cmd),
        .i_data (q_dat), .i_key (r_k), .i_rd_idx (r_idx), .o_stat (q_st)
    );
    nfd_row u_blk (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_wr_idx (b_wi), .i_cmd (b_cmd),
        .i_data (b_dat), .i_key (r_k), .i_rd_idx (r_idx), .o_stat (b_st)
    );

    assign ret_state = (r_cmd == nfd_pkg::CMD_TICK) ? nfd_pkg::ST_LWALK : nfd_pkg::ST_QWALK;
    assign last_slot = (r_idx == {IW{1'b1}});
    assign newf      = (&q_st.hit_entry.faults) ? q_st.hit_entry.faults
                                                : q_st.hit_entry.faults + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= nfd_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx <= n_idx;
        r_k   <= n_k;
        r_a   <= n_a;
        r_h   <= n_h;
        if (accept) begin
            r_cmd  <= s_axis_tuser;
            r_now  <= s_axis_tdata[31:0];
            r_key  <= s_axis_tdata[95:32];
            r_addr <= s_axis_tdata[143:96];
            r_cmpl <= s_axis_tdata[144];
        end
    end

    always_comb begin
        n_state   = r_state;
        n_idx     = r_idx;
        n_k       = r_k;
        n_a       = r_a;
        n_h       = r_h;
        emit      = 1'b0;
        push_last = 1'b0;
        em_kind   = nfd_pkg::EV_BCAST;
        em_key    = '0;
        em_addr   = '0;
        l_wi      = r_idx;
        q_wi      = r_idx;
        b_wi      = r_idx;
        l_cmd     = '0;
        q_cmd     = '0;
        b_cmd     = '0;
        l_dat     = '{key: r_key, addr: r_addr, tm: r_now, faults: '0};
        q_dat     = '{key: r_k, addr: r_a, tm: r_h, faults: nfd_pkg::FLT_W'(1)};
        b_dat     = '{key: r_k, addr: r_a, tm: r_now, faults: '0};
        case (r_state)
            nfd_pkg::ST_IDLE: begin
                if (accept) begin
                    n_idx = '0;
                    case (s_axis_tuser)
                        nfd_pkg::CMD_HEARD: n_state = nfd_pkg::ST_HEARD;
                        nfd_pkg::CMD_TICK:  n_state = nfd_pkg::ST_BCAST;
                        nfd_pkg::CMD_QSWP:  n_state = nfd_pkg::ST_QWALK;
                        default:            n_state = nfd_pkg::ST_BWALK;
                    endcase
                end
            end
            nfd_pkg::ST_HEARD: begin
                if (!r_cmpl) begin
                    n_state = nfd_pkg::ST_FIN;
                end else if (l_st.hit) begin
                    l_wi          = l_st.hit_idx;
                    l_cmd.wr_time = 1'b1;
                    n_state       = nfd_pkg::ST_FIN;
                end else if (can_emit) begin
                    emit    = 1'b1;
                    em_key  = r_key;
                    em_addr = r_addr;
                    if (l_st.free) begin
                        l_wi         = l_st.free_idx;
                        l_cmd.wr_all = 1'b1;
                        em_kind      = nfd_pkg::EV_UP;
                    end else begin
                        em_kind = nfd_pkg::EV_FULL;
                    end
                    n_state = nfd_pkg::ST_FIN;
                end
            end
            nfd_pkg::ST_BCAST: begin
                if (can_emit) begin
                    emit    = 1'b1;
                    em_kind = nfd_pkg::EV_BCAST;
                    em_addr = {nfd_pkg::ADDR_W{1'b1}};
                    n_idx   = '0;
                    n_state = (r_timeout != '0) ? nfd_pkg::ST_LWALK : nfd_pkg::ST_FIN;
                end
            end
            nfd_pkg::ST_LWALK: begin
                if (l_st.rd_valid && (({1'b0, l_st.rd_entry.tm} + {1'b0, r_timeout})
                                      < {1'b0, r_now})) begin
                    if (can_emit) begin
                        l_cmd.clr = 1'b1;
                        emit      = 1'b1;
                        em_kind   = nfd_pkg::EV_DOWN;
                        em_key    = l_st.rd_entry.key;
                        em_addr   = l_st.rd_entry.addr;
                        if (r_hold != '0) begin
                            n_k     = l_st.rd_entry.key;
                            n_a     = l_st.rd_entry.addr;
                            n_h     = l_st.rd_entry.tm;
                            n_state = nfd_pkg::ST_QUAR;
                        end else begin
                            n_idx   = r_idx + 1'b1;
                            n_state = last_slot ? nfd_pkg::ST_FIN : nfd_pkg::ST_LWALK;
                        end
                    end
                end else begin
                    n_idx   = r_idx + 1'b1;
                    n_state = last_slot ? nfd_pkg::ST_FIN : nfd_pkg::ST_LWALK;
                end
            end
            nfd_pkg::ST_QUAR: begin
                n_idx   = r_idx + 1'b1;
                n_state = last_slot ? nfd_pkg::ST_FIN : ret_state;
                if (q_st.hit) begin
                    q_wi            = q_st.hit_idx;
                    q_cmd.wr_faults = 1'b1;
                    q_dat.faults    = newf;
                    if ((r_thr != '0) && (newf > r_thr)) begin
                        q_cmd.clr = 1'b1;
                        n_a       = q_st.hit_entry.addr;
                        n_idx     = r_idx;
                        n_state   = nfd_pkg::ST_BLK;
                    end
                end else if (q_st.free) begin
                    q_wi         = q_st.free_idx;
                    q_cmd.wr_all = 1'b1;
                end else if (can_emit) begin
                    emit    = 1'b1;
                    em_kind = nfd_pkg::EV_FULL;
                    em_key  = r_k;
                    em_addr = r_a;
                end else begin
                    n_idx   = r_idx;
                    n_state = r_state;
                end
            end
            nfd_pkg::ST_BLK: begin
                n_idx   = r_idx + 1'b1;
                n_state = last_slot ? nfd_pkg::ST_FIN : ret_state;
                if (!b_st.hit) begin
                    if (can_emit) begin
                        emit    = 1'b1;
                        em_key  = r_k;
                        em_addr = r_a;
                        if (b_st.free) begin
                            b_wi         = b_st.free_idx;
                            b_cmd.wr_all = 1'b1;
                            em_kind      = nfd_pkg::EV_BLOCK;
                        end else begin
                            em_kind = nfd_pkg::EV_FULL;
                        end
                    end else begin
                        n_idx   = r_idx;
                        n_state = r_state;
                    end
                end
            end
            nfd_pkg::ST_QWALK: begin
                n_idx   = r_idx + 1'b1;
                n_state = last_slot ? nfd_pkg::ST_FIN : nfd_pkg::ST_QWALK;
                if (q_st.rd_valid && (({1'b0, q_st.rd_entry.tm} + {1'b0, r_hold})
                                      < {1'b0, r_now})) begin
                    q_cmd.clr = 1'b1;
                    if ((r_thr != '0) && (q_st.rd_entry.faults > r_thr)) begin
                        n_k     = q_st.rd_entry.key;
                        n_a     = q_st.rd_entry.addr;
                        n_idx   = r_idx;
                        n_state = nfd_pkg::ST_BLK;
                    end
                end
            end
            nfd_pkg::ST_BWALK: begin
                if (b_st.rd_valid && (({1'b0, b_st.rd_entry.tm} + {1'b0, r_retry})
                                      < {1'b0, r_now})) begin
                    if (can_emit) begin
                        b_cmd.clr = 1'b1;
                        emit      = 1'b1;
                        em_kind   = nfd_pkg::EV_UNBLOCK;
                        em_key    = b_st.rd_entry.key;
                        em_addr   = b_st.rd_entry.addr;
                        n_idx     = r_idx + 1'b1;
                        n_state   = last_slot ? nfd_pkg::ST_FIN : nfd_pkg::ST_BWALK;
                    end
                end else begin
                    n_idx   = r_idx + 1'b1;
                    n_state = last_slot ? nfd_pkg::ST_FIN : nfd_pkg::ST_BWALK;
                end
            end
            nfd_pkg::ST_FIN: begin
                if (!r_pend_v) begin
                    n_state = nfd_pkg::ST_IDLE;
                end else if (can_emit) begin
                    push_last = 1'b1;
                    n_state   = nfd_pkg::ST_IDLE;
                end
            end
            default: n_state = nfd_pkg::ST_IDLE;
        endcase
    end

    // hold the newest result back until the next one shows whether it is last
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_pend_v <= 1'b0;
        end else begin
            if ((emit && r_pend_v) || push_last) begin
                r_out_v <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_v <= 1'b0;
            end
            if (emit) begin
                r_pend_v <= 1'b1;
            end else if (push_last) begin
                r_pend_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_pend_kind <= em_kind;
            r_pend_key  <= em_key;
            r_pend_addr <= em_addr;
        end
        if ((emit && r_pend_v) || push_last) begin
            r_out_kind <= r_pend_kind;
            r_out_key  <= r_pend_key;
            r_out_addr <= r_pend_addr;
            r_out_last <= push_last;
        end
    end

    `NFD_ASSERT_NOW(a_idle_no_pend, r_state == nfd_pkg::ST_IDLE, !r_pend_v, "result left pending")
    `NFD_ASSERT_NEXT(a_fin_exit, r_state == nfd_pkg::ST_FIN,
        r_state == nfd_pkg::ST_IDLE || r_state == nfd_pkg::ST_FIN, "bad exit from finish")
    `NFD_ASSERT_NOW(a_emit_room, emit || push_last, can_emit, "result with no room")
    `NFD_ASSERT_NEXT(a_last_sent, push_last, r_out_v && r_out_last && !r_pend_v,
        "last result not presented")

endmodule
